@@ design/jts_pkg.sv @@
// Shared types for the JSON token scanner: input word, token word, token kinds.
// Depends on nothing; used by the scanner core and its checker.
package jts_pkg;

  localparam int DEF_LENGTH_BITS   = 24;
  localparam int DEF_POSITION_BITS = 32;
  localparam int QUEUE_DEPTH       = 4;

  typedef enum logic [3:0] {
    K_LBRACE   = 4'd0,
    K_RBRACE   = 4'd1,
    K_LBRACKET = 4'd2,
    K_RBRACKET = 4'd3,
    K_COLON    = 4'd4,
    K_COMMA    = 4'd5,
    K_STRING   = 4'd6,
    K_NUMBER   = 4'd7,
    K_BOOL     = 4'd8,
    K_NULL     = 4'd9,
    K_ERROR    = 4'd10,
    K_EOF      = 4'd11
  } kind_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  byte_count;
  } item_t;

  typedef struct packed {
    kind_t       token_kind;
    logic        escaped;
    logic        is_float;
    logic [31:0] start_offset;
    logic [23:0] text_length;
    logic        last;
  } token_t;

endpackage

@@ design/json_token_scanner_core.sv @@
// JSON token scanner top level: scanner state update and token output queue.
// Depends on jts_pkg.

// Takes one decoded code point per cycle on the item channel and emits JSON
// tokens on the token channel. Each accepted word is scanned in the cycle it
// is accepted: the scanner state registers update at that edge and the zero,
// one or two tokens it causes are written into a four-entry output queue.
// item_ready is high while the queue has room for two tokens, so with the
// token side always ready the block sustains one item per cycle; the rate
// drops only when items that end a number, keyword or unterminated string
// and are tokens themselves push two tokens faster than the single token
// port drains them. The last bit marks the final token caused by one item.
// Offsets wrap at 2^POSITION_BITS and lengths saturate at 2^LENGTH_BITS - 1;
// the token fields carry the low 32 and 24 bits.
module json_token_scanner_core #(
  parameter int LENGTH_BITS   = jts_pkg::DEF_LENGTH_BITS,
  parameter int POSITION_BITS = jts_pkg::DEF_POSITION_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  jts_pkg::item_t  item,
  output logic            token_valid,
  input  logic            token_ready,
  output jts_pkg::token_t token
);

  localparam int PTR_W = $clog2(jts_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(jts_pkg::QUEUE_DEPTH + 1);

  localparam logic [20:0] CH_NUL    = 21'h00;
  localparam logic [20:0] CH_TAB    = 21'h09;
  localparam logic [20:0] CH_LF     = 21'h0A;
  localparam logic [20:0] CH_CR     = 21'h0D;
  localparam logic [20:0] CH_SPACE  = 21'h20;
  localparam logic [20:0] CH_QUOTE  = 21'h22;
  localparam logic [20:0] CH_PLUS   = 21'h2B;
  localparam logic [20:0] CH_COMMA  = 21'h2C;
  localparam logic [20:0] CH_MINUS  = 21'h2D;
  localparam logic [20:0] CH_DOT    = 21'h2E;
  localparam logic [20:0] CH_0      = 21'h30;
  localparam logic [20:0] CH_9      = 21'h39;
  localparam logic [20:0] CH_COLON  = 21'h3A;
  localparam logic [20:0] CH_UPPERE = 21'h45;
  localparam logic [20:0] CH_LBRKT  = 21'h5B;
  localparam logic [20:0] CH_BSLASH = 21'h5C;
  localparam logic [20:0] CH_RBRKT  = 21'h5D;
  localparam logic [20:0] CH_A      = 21'h61;
  localparam logic [20:0] CH_E      = 21'h65;
  localparam logic [20:0] CH_Z      = 21'h7A;
  localparam logic [20:0] CH_LBRACE = 21'h7B;
  localparam logic [20:0] CH_RBRACE = 21'h7D;

  localparam logic [39:0] KW_TRUE  = 40'h0074727565;
  localparam logic [39:0] KW_FALSE = 40'h66616C7365;
  localparam logic [39:0] KW_NULL  = 40'h006E756C6C;

  typedef enum logic [7:0] {
    M_IDLE     = 8'b0000_0001,
    M_WORD     = 8'b0000_0010,
    M_STR      = 8'b0000_0100,
    M_STR_ESC  = 8'b0000_1000,
    M_MINUS    = 8'b0001_0000,
    M_INT      = 8'b0010_0000,
    M_EXP_SIGN = 8'b0100_0000,
    M_EXP      = 8'b1000_0000
  } mode_t;

  function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] a,
                                                     input logic [2:0] b);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, a} + (LENGTH_BITS + 1)'(b);
    return s[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : s[LENGTH_BITS-1:0];
  endfunction

  function automatic jts_pkg::token_t make_tok(input jts_pkg::kind_t k, input logic esc,
                                               input logic flt,
                                               input logic [POSITION_BITS-1:0] start,
                                               input logic [LENGTH_BITS-1:0] len);
    jts_pkg::token_t t;
    logic [63:0]     start_w;
    logic [31:0]     len_w;
    start_w        = 64'(start);
    len_w          = 32'(len);
    t.token_kind   = k;
    t.escaped      = esc;
    t.is_float     = flt;
    t.start_offset = start_w[31:0];
    t.text_length  = len_w[23:0];
    t.last         = 1'b0;
    return t;
  endfunction

  // scanner state
  mode_t                    scan_mode, scan_mode_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] token_start, token_start_next;
  logic [LENGTH_BITS-1:0]   token_length, token_length_next;
  logic                     escape_seen, escape_seen_next;
  logic                     float_seen, float_seen_next;
  logic                     dot_seen, dot_seen_next;
  logic [39:0]              keyword_letters, keyword_letters_next;

  logic [20:0]              cp;
  logic [2:0]               bc;
  logic                     is_dig, is_low;
  logic [LENGTH_BITS-1:0]   bc_len, len_inc;

  // idle scan of the current word, used directly and for rescans
  logic                     idle_emit, idle_begin, idle_kw_load;
  jts_pkg::kind_t           idle_kind;
  mode_t                    idle_mode;
  logic [POSITION_BITS-1:0] idle_start;
  jts_pkg::token_t          idle_tok;

  logic                     mode_emit, rescan;
  jts_pkg::token_t          mode_tok;
  jts_pkg::kind_t           word_kind;
  logic                     num_float;
  logic [1:0]               push_n;
  jts_pkg::token_t          tok0, tok1;

  // output queue
  jts_pkg::token_t          queue [jts_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]         head, tail;
  logic [CNT_W-1:0]         count;
  logic                     accept, pop;

  assign cp      = item.code_point;
  assign bc      = item.byte_count;
  assign is_dig  = (cp >= CH_0) && (cp <= CH_9);
  assign is_low  = (cp >= CH_A) && (cp <= CH_Z);
  assign bc_len  = LENGTH_BITS'(bc);
  assign len_inc = sat_add(token_length, bc);

  always_comb begin
    idle_emit    = 1'b0;
    idle_begin   = 1'b0;
    idle_kw_load = 1'b0;
    idle_kind    = jts_pkg::K_ERROR;
    idle_mode    = M_IDLE;
    idle_start   = byte_position;
    case (cp) inside
      CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
      CH_LBRACE: begin idle_emit = 1'b1; idle_kind = jts_pkg::K_LBRACE;   end
      CH_RBRACE: begin idle_emit = 1'b1; idle_kind = jts_pkg::K_RBRACE;   end
      CH_LBRKT:  begin idle_emit = 1'b1; idle_kind = jts_pkg::K_LBRACKET; end
      CH_RBRKT:  begin idle_emit = 1'b1; idle_kind = jts_pkg::K_RBRACKET; end
      CH_COLON:  begin idle_emit = 1'b1; idle_kind = jts_pkg::K_COLON;    end
      CH_COMMA:  begin idle_emit = 1'b1; idle_kind = jts_pkg::K_COMMA;    end
      CH_NUL:    begin idle_emit = 1'b1; idle_kind = jts_pkg::K_EOF;      end
      CH_QUOTE: begin
        // string text starts after the opening quote
        idle_begin = 1'b1;
        idle_mode  = M_STR;
        idle_start = byte_position + POSITION_BITS'(bc);
      end
      CH_MINUS: begin
        idle_begin = 1'b1;
        idle_mode  = M_MINUS;
      end
      default: begin
        if (is_low) begin
          idle_begin   = 1'b1;
          idle_kw_load = 1'b1;
          idle_mode    = M_WORD;
        end else if (is_dig) begin
          idle_begin = 1'b1;
          idle_mode  = M_INT;
        end else begin
          idle_emit = 1'b1;
        end
      end
    endcase
    idle_tok = make_tok(idle_kind, 1'b0, 1'b0, byte_position,
                        (idle_kind == jts_pkg::K_EOF) ? '0 : bc_len);
  end

  always_comb begin
    word_kind = jts_pkg::K_ERROR;
    if ((token_length == LENGTH_BITS'(4) && keyword_letters == KW_TRUE) ||
        (token_length == LENGTH_BITS'(5) && keyword_letters == KW_FALSE)) begin
      word_kind = jts_pkg::K_BOOL;
    end else if (token_length == LENGTH_BITS'(4) && keyword_letters == KW_NULL) begin
      word_kind = jts_pkg::K_NULL;
    end
  end

  assign num_float = float_seen || (token_length > LENGTH_BITS'(18));

  always_comb begin
    scan_mode_next       = scan_mode;
    byte_position_next   = byte_position + POSITION_BITS'(bc);
    token_start_next     = token_start;
    token_length_next    = token_length;
    escape_seen_next     = escape_seen;
    float_seen_next      = float_seen;
    dot_seen_next        = dot_seen;
    keyword_letters_next = keyword_letters;
    mode_emit            = 1'b0;
    rescan               = 1'b0;
    mode_tok = make_tok(jts_pkg::K_ERROR, 1'b0, 1'b0, token_start, token_length);

    unique case (scan_mode)
      M_WORD: begin
        if (is_low) begin
          // keep only the first five letters
          if (token_length < LENGTH_BITS'(5)) begin
            keyword_letters_next = {keyword_letters[31:0], cp[7:0]};
          end
          token_length_next = len_inc;
        end else begin
          mode_emit = 1'b1;
          mode_tok  = make_tok(word_kind, 1'b0, 1'b0, token_start, token_length);
          rescan    = 1'b1;
        end
      end
      M_STR, M_STR_ESC: begin
        if (cp == CH_NUL) begin
          // unterminated string: error for the text so far, then eof
          mode_emit = 1'b1;
          rescan    = 1'b1;
        end else if (scan_mode == M_STR_ESC) begin
          token_length_next = len_inc;
          scan_mode_next    = M_STR;
        end else if (cp == CH_BSLASH) begin
          escape_seen_next  = 1'b1;
          token_length_next = len_inc;
          scan_mode_next    = M_STR_ESC;
        end else if (cp == CH_QUOTE) begin
          mode_emit      = 1'b1;
          mode_tok       = make_tok(jts_pkg::K_STRING, escape_seen, 1'b0,
                                    token_start, token_length);
          scan_mode_next = M_IDLE;
        end else begin
          token_length_next = len_inc;
        end
      end
      M_MINUS: begin
        if (is_dig) begin
          token_length_next = len_inc;
          scan_mode_next    = M_INT;
        end else begin
          mode_emit      = 1'b1;
          scan_mode_next = M_IDLE;
        end
      end
      M_INT: begin
        if (is_dig) begin
          token_length_next = len_inc;
        end else if (cp == CH_DOT) begin
          float_seen_next = 1'b1;
          if (dot_seen) begin
            mode_emit      = 1'b1;
            scan_mode_next = M_IDLE;
          end else begin
            dot_seen_next     = 1'b1;
            token_length_next = len_inc;
          end
        end else if (cp == CH_E || cp == CH_UPPERE) begin
          float_seen_next   = 1'b1;
          token_length_next = len_inc;
          scan_mode_next    = M_EXP_SIGN;
        end else begin
          mode_emit = 1'b1;
          mode_tok  = make_tok(jts_pkg::K_NUMBER, 1'b0, num_float, token_start,
                               token_length);
          rescan    = 1'b1;
        end
      end
      M_EXP_SIGN: begin
        // the offender is counted into the error length
        token_length_next = len_inc;
        if (cp == CH_PLUS || cp == CH_MINUS || is_dig) begin
          scan_mode_next = M_EXP;
        end else begin
          mode_emit      = 1'b1;
          mode_tok       = make_tok(jts_pkg::K_ERROR, 1'b0, 1'b0, token_start, len_inc);
          scan_mode_next = M_IDLE;
        end
      end
      M_EXP: begin
        if (is_dig) begin
          token_length_next = len_inc;
        end else begin
          mode_emit = 1'b1;
          mode_tok  = make_tok(jts_pkg::K_NUMBER, 1'b0, num_float, token_start,
                               token_length);
          rescan    = 1'b1;
        end
      end
      default: rescan = 1'b1;
    endcase

    if (rescan) begin
      scan_mode_next = idle_mode;
      if (idle_begin) begin
        // a string starts empty, the quote is not part of its text
        token_start_next  = idle_start;
        token_length_next = (idle_mode == M_STR) ? '0 : bc_len;
        escape_seen_next  = 1'b0;
        float_seen_next   = 1'b0;
        dot_seen_next     = 1'b0;
      end
      if (idle_kw_load) begin
        keyword_letters_next = 40'(cp[7:0]);
      end
    end
  end

  always_comb begin
    push_n    = 2'(mode_emit) + 2'(rescan && idle_emit);
    tok0      = mode_emit ? mode_tok : idle_tok;
    tok0.last = (push_n == 2'd1);
    tok1      = idle_tok;
    tok1.last = 1'b1;
  end

  assign item_ready  = (count <= CNT_W'(jts_pkg::QUEUE_DEPTH - 2));
  assign accept      = item_valid && item_ready;
  assign token_valid = (count != '0);
  assign token       = queue[head];
  assign pop         = token_valid && token_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode       <= M_IDLE;
      byte_position   <= '0;
      token_start     <= '0;
      token_length    <= '0;
      escape_seen     <= 1'b0;
      float_seen      <= 1'b0;
      dot_seen        <= 1'b0;
      keyword_letters <= '0;
    end else if (accept) begin
      scan_mode       <= scan_mode_next;
      byte_position   <= byte_position_next;
      token_start     <= token_start_next;
      token_length    <= token_length_next;
      escape_seen     <= escape_seen_next;
      float_seen      <= float_seen_next;
      dot_seen        <= dot_seen_next;
      keyword_letters <= keyword_letters_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && push_n != 2'd0) begin
      queue[tail] <= tok0;
    end
    if (accept && push_n == 2'd2) begin
      queue[tail + PTR_W'(1)] <= tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (accept) begin
        tail <= tail + PTR_W'(push_n);
      end
      if (pop) begin
        head <= head + PTR_W'(1);
      end
      count <= count + CNT_W'(accept ? push_n : 2'd0) - CNT_W'(pop);
    end
  end

endmodule

@@ design/jts_checker.sv @@
// Port-level checker for the JSON token scanner, bound to the top level.
// Depends on jts_pkg and json_token_scanner_core.
module jts_checker (
  input logic            clk,
  input logic            rst,
  input logic            item_ready,
  input logic            token_valid,
  input logic            token_ready,
  input jts_pkg::token_t token
);

  // the queue comes out of reset empty and open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!token_valid && item_ready))
    else $error("queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && !token_ready |=> token_valid && $stable(token))
    else $error("stalled token word changed");

  a_eof_len: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.token_kind == jts_pkg::K_EOF |-> token.text_length == '0)
    else $error("eof token with nonzero length");

  a_esc_kind: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.escaped |-> token.token_kind == jts_pkg::K_STRING)
    else $error("escape flag on a non-string token");

  a_float_kind: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.is_float |-> token.token_kind == jts_pkg::K_NUMBER)
    else $error("float flag on a non-number token");

endmodule

bind json_token_scanner_core jts_checker u_jts_checker (
  .clk         (clk),
  .rst         (rst),
  .item_ready  (item_ready),
  .token_valid (token_valid),
  .token_ready (token_ready),
  .token       (token)
);

@@ verif/jts_token_checker.sv @@
// Token checker for the JSON token scanner: predicts the tokens of every accepted
// input word and compares them with the token channel. Depends on jts_pkg.
module jts_token_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  logic            item_ready,
  input  jts_pkg::item_t  item,
  input  logic            token_valid,
  input  logic            token_ready,
  input  jts_pkg::token_t token,
  output int              fail_count,
  output int              pending,
  output int              tokens_checked
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_WORD     = 8'b0000_0010,
    S_STR      = 8'b0000_0100,
    S_STR_ESC  = 8'b0000_1000,
    S_MINUS    = 8'b0001_0000,
    S_INT      = 8'b0010_0000,
    S_EXP_SIGN = 8'b0100_0000,
    S_EXP      = 8'b1000_0000
  } scan_t;

  localparam logic [39:0] KW_TRUE  = 40'h74727565;
  localparam logic [39:0] KW_FALSE = 40'h66616C7365;
  localparam logic [39:0] KW_NULL  = 40'h6E756C6C;
  localparam int LONG_NUMBER  = 18;
  localparam int KEEP_LETTERS = 5;
  localparam int REPORT_LIMIT = 60;

  scan_t       mode;
  logic [31:0] pos;
  logic [31:0] tok_start;
  logic [23:0] tok_len;
  logic        esc_flag;
  logic        flt_flag;
  logic        dot_flag;
  logic [39:0] letters;

  jts_pkg::token_t expected_tokens[$];
  jts_pkg::token_t step_tokens[2];
  int              step_count;

  function automatic logic [23:0] len_add(input logic [23:0] a, input logic [2:0] bc);
    logic [24:0] s;
    s = {1'b0, a} + 25'(bc);
    return s[24] ? '1 : s[23:0];
  endfunction

  function automatic bit is_digit(input logic [20:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_lower(input logic [20:0] c);
    return c >= "a" && c <= "z";
  endfunction

  task automatic push_token(input jts_pkg::kind_t k, input logic e, input logic f,
                            input logic [31:0] st, input logic [23:0] ln);
    if (step_count < 2) begin
      step_tokens[step_count] = '{token_kind: k, escaped: e, is_float: f,
                                  start_offset: st, text_length: ln, last: 1'b0};
      step_count++;
    end
  endtask

  task automatic begin_token(input scan_t m, input logic [31:0] st, input logic [23:0] ln);
    mode      = m;
    tok_start = st;
    tok_len   = ln;
    esc_flag  = 1'b0;
    flt_flag  = 1'b0;
    dot_flag  = 1'b0;
  endtask

  task automatic end_number();
    push_token(jts_pkg::K_NUMBER, 1'b0, flt_flag || tok_len > LONG_NUMBER, tok_start,
               tok_len);
    mode = S_IDLE;
  endtask

  task automatic end_error();
    push_token(jts_pkg::K_ERROR, 1'b0, 1'b0, tok_start, tok_len);
    mode = S_IDLE;
  endtask

  // Scan a word that stands between tokens, at byte offset 'at'.
  task automatic scan_fresh(input logic [20:0] cp, input logic [2:0] bc, input logic [31:0] at);
    mode = S_IDLE;
    case (cp)
      " ", "\t", "\n", "\r": ;
      "{": push_token(jts_pkg::K_LBRACE, 1'b0, 1'b0, at, len_add(24'd0, bc));
      "}": push_token(jts_pkg::K_RBRACE, 1'b0, 1'b0, at, len_add(24'd0, bc));
      "[": push_token(jts_pkg::K_LBRACKET, 1'b0, 1'b0, at, len_add(24'd0, bc));
      "]": push_token(jts_pkg::K_RBRACKET, 1'b0, 1'b0, at, len_add(24'd0, bc));
      ":": push_token(jts_pkg::K_COLON, 1'b0, 1'b0, at, len_add(24'd0, bc));
      ",": push_token(jts_pkg::K_COMMA, 1'b0, 1'b0, at, len_add(24'd0, bc));
      21'd0: push_token(jts_pkg::K_EOF, 1'b0, 1'b0, at, 24'd0);
      "\"": begin_token(S_STR, at + 32'(bc), 24'd0);
      "-": begin_token(S_MINUS, at, len_add(24'd0, bc));
      default: begin
        if (is_lower(cp)) begin
          begin_token(S_WORD, at, len_add(24'd0, bc));
          letters = 40'(cp);
        end else if (is_digit(cp)) begin
          begin_token(S_INT, at, len_add(24'd0, bc));
        end else begin
          push_token(jts_pkg::K_ERROR, 1'b0, 1'b0, at, len_add(24'd0, bc));
        end
      end
    endcase
  endtask

  task automatic predict_word(input logic [20:0] cp, input logic [2:0] bc);
    logic [31:0]    here;
    jts_pkg::kind_t kw_kind;
    here       = pos;
    step_count = 0;
    pos        = pos + 32'(bc);
    unique case (mode)
      S_WORD: begin
        if (is_lower(cp)) begin
          if (tok_len < KEEP_LETTERS) letters = {letters[31:0], cp[7:0]};
          tok_len = len_add(tok_len, bc);
        end else begin
          kw_kind = jts_pkg::K_ERROR;
          if ((tok_len == 4 && letters == KW_TRUE) || (tok_len == 5 && letters == KW_FALSE))
            kw_kind = jts_pkg::K_BOOL;
          else if (tok_len == 4 && letters == KW_NULL)
            kw_kind = jts_pkg::K_NULL;
          push_token(kw_kind, 1'b0, 1'b0, tok_start, tok_len);
          scan_fresh(cp, bc, here);
        end
      end
      S_STR, S_STR_ESC: begin
        if (cp == 21'd0) begin
          // text so far is an error, then the zero is scanned again as eof
          end_error();
          scan_fresh(cp, bc, here);
        end else if (mode == S_STR_ESC) begin
          tok_len = len_add(tok_len, bc);
          mode    = S_STR;
        end else if (cp == "\\") begin
          esc_flag = 1'b1;
          tok_len  = len_add(tok_len, bc);
          mode     = S_STR_ESC;
        end else if (cp == "\"") begin
          push_token(jts_pkg::K_STRING, esc_flag, 1'b0, tok_start, tok_len);
          mode = S_IDLE;
        end else begin
          tok_len = len_add(tok_len, bc);
        end
      end
      S_MINUS: begin
        if (is_digit(cp)) begin
          tok_len = len_add(tok_len, bc);
          mode    = S_INT;
        end else begin
          end_error();
        end
      end
      S_INT: begin
        if (is_digit(cp)) begin
          tok_len = len_add(tok_len, bc);
        end else if (cp == ".") begin
          flt_flag = 1'b1;
          if (dot_flag) begin
            end_error();
          end else begin
            dot_flag = 1'b1;
            tok_len  = len_add(tok_len, bc);
          end
        end else if (cp == "e" || cp == "E") begin
          flt_flag = 1'b1;
          tok_len  = len_add(tok_len, bc);
          mode     = S_EXP_SIGN;
        end else begin
          end_number();
          scan_fresh(cp, bc, here);
        end
      end
      S_EXP_SIGN: begin
        // the marker's follower counts toward the error length too
        tok_len = len_add(tok_len, bc);
        if (cp == "+" || cp == "-" || is_digit(cp)) mode = S_EXP;
        else end_error();
      end
      S_EXP: begin
        if (is_digit(cp)) begin
          tok_len = len_add(tok_len, bc);
        end else begin
          end_number();
          scan_fresh(cp, bc, here);
        end
      end
      default: scan_fresh(cp, bc, here);
    endcase
    for (int i = 0; i < step_count; i++) begin
      if (i == step_count - 1) step_tokens[i].last = 1'b1;
      expected_tokens.push_back(step_tokens[i]);
    end
  endtask

  // Keep the log short when the block is badly off: count every mismatch,
  // print only the first ones.
  task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      if (fail_count < REPORT_LIMIT) $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_token(input jts_pkg::token_t got);
    jts_pkg::token_t want;
    tokens_checked++;
    if (expected_tokens.size() == 0) begin
      if (fail_count < REPORT_LIMIT)
        $error("token with none expected: kind %0d start %0d length %0d",
               got.token_kind, got.start_offset, got.text_length);
      fail_count++;
      return;
    end
    want = expected_tokens.pop_front();
    flag_field("token_kind", 32'(want.token_kind), 32'(got.token_kind));
    flag_field("escaped", 32'(want.escaped), 32'(got.escaped));
    flag_field("is_float", 32'(want.is_float), 32'(got.is_float));
    flag_field("start_offset", want.start_offset, got.start_offset);
    flag_field("text_length", 32'(want.text_length), 32'(got.text_length));
    flag_field("last", 32'(want.last), 32'(got.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode           = S_IDLE;
      pos            = '0;
      tok_start      = '0;
      tok_len        = '0;
      esc_flag       = 1'b0;
      flt_flag       = 1'b0;
      dot_flag       = 1'b0;
      letters        = '0;
      fail_count     = 0;
      tokens_checked = 0;
      expected_tokens.delete();
    end else begin
      if (item_valid && item_ready) predict_word(item.code_point, item.byte_count);
      if (token_valid && token_ready) check_token(token);
    end
    pending <= expected_tokens.size();
  end

endmodule

@@ verif/tb_json_token_scanner_core.sv @@
// Testbench top for the JSON token scanner: drives code point words with random
// gaps and token back-pressure, and reports the verdict of jts_token_checker.
// Depends on jts_pkg, json_token_scanner_core and jts_token_checker.
module tb_json_token_scanner_core;

  localparam int SINK_HOLD   = 300;
  localparam int DRAIN_TAIL  = 24;
  localparam int RANDOM_END  = 475;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            item_valid = 1'b0;
  logic            item_ready;
  jts_pkg::item_t  item = '0;
  logic            token_valid;
  logic            token_ready = 1'b0;
  jts_pkg::token_t token;

  int fail_count;
  int pending;
  int tokens_checked;
  int words_sent = 0;
  bit no_idle = 1'b0;
  bit stall_sink = 1'b0;

  string punct_set = "{}[]:,";
  string space_set = " \t\n\r";
  string odd_set   = "x.:} a";
  string kw_list[3] = '{"true", "false", "null"};

  json_token_scanner_core uut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token       (token)
  );

  jts_token_checker token_check (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .token_valid    (token_valid),
    .token_ready    (token_ready),
    .token          (token),
    .fail_count     (fail_count),
    .pending        (pending),
    .tokens_checked (tokens_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [2:0] ascii_bc();
    return ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7)) : 3'd1;
  endfunction

  task automatic send_word(input logic [20:0] cp, input logic [2:0] bc);
    int gap;
    gap = (no_idle || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{code_point: cp, byte_count: bc};
    do @(posedge clk); while (!item_ready);
    words_sent++;
  endtask

  task automatic send_char(input byte c);
    send_word({13'd0, c}, ascii_bc());
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_digits(input int n);
    repeat (n) send_word(21'("0" + $urandom_range(0, 9)), ascii_bc());
  endtask

  // Whatever breaks a number; a zero is consumed with the error as well.
  task automatic send_offender();
    if ($urandom_range(0, 3) == 0) send_word(21'd0, ascii_bc());
    else send_char(odd_set[$urandom_range(0, odd_set.len() - 1)]);
  endtask

  task automatic send_separator();
    case ($urandom_range(0, 9))
      0: send_word(21'd0, ascii_bc());
      1, 2, 3, 4: send_char(space_set[$urandom_range(0, space_set.len() - 1)]);
      default: send_char(punct_set[$urandom_range(0, punct_set.len() - 1)]);
    endcase
  endtask

  task automatic send_string();
    int n;
    byte c;
    send_char("\"");
    n = $urandom_range(0, 6);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0, 1, 2: send_word(21'($urandom_range(128, 21'h10FFFF)), 3'($urandom_range(2, 4)));
        3, 4, 5: begin
          send_char("\\");
          send_char(8'($urandom_range(32, 126)));
        end
        default: begin
          c = 8'($urandom_range(32, 126));
          if (c == "\"" || c == "\\") c = "x";
          send_char(c);
        end
      endcase
    end
    if ($urandom_range(0, 11) == 0) begin
      // run into the end of input, sometimes right after a backslash
      if ($urandom_range(0, 1)) send_char("\\");
      send_word(21'd0, ascii_bc());
    end else begin
      send_char("\"");
    end
  endtask

  task automatic send_number();
    int flavor;
    flavor = $urandom_range(0, 11);
    if (flavor == 0) begin
      send_char("-");
      send_offender();
      return;
    end
    if ($urandom_range(0, 2) == 0) send_char("-");
    send_digits(flavor == 1 ? $urandom_range(17, 22) : $urandom_range(1, 4));
    if (flavor == 2 || $urandom_range(0, 2) == 0) begin
      send_char(".");
      send_digits($urandom_range(1, 3));
      if (flavor == 2) begin
        send_char(".");
        return;
      end
    end
    if (flavor == 3 || $urandom_range(0, 3) == 0) begin
      send_char($urandom_range(0, 1) ? "e" : "E");
      if (flavor == 3) begin
        send_offender();
        return;
      end
      if ($urandom_range(0, 1)) send_char($urandom_range(0, 1) ? "+" : "-");
      send_digits($urandom_range(1, 2));
    end
    send_separator();
  endtask

  task automatic send_keyword();
    int pick;
    pick = $urandom_range(0, 5);
    if (pick < 3) begin
      send_text(kw_list[pick]);
    end else begin
      repeat ($urandom_range(1, 7)) send_word(21'("a" + $urandom_range(0, 25)), ascii_bc());
    end
    send_separator();
  endtask

  task automatic send_random_token();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) send_char(punct_set[$urandom_range(0, punct_set.len() - 1)]);
    else if (pick < 28) send_char(space_set[$urandom_range(0, space_set.len() - 1)]);
    else if (pick < 48) send_string();
    else if (pick < 70) send_number();
    else if (pick < 88) send_keyword();
    else if (pick < 92) send_word(21'd0, 3'($urandom_range(0, 7)));
    else send_word(21'($urandom), 3'($urandom_range(0, 7)));
  endtask

  // Drop valid and hold until every predicted token has come out.
  task automatic drain_tokens();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : token_sink
    @(posedge clk);
    forever begin
      if (stall_sink) begin
        token_ready <= 1'b0;
        repeat (SINK_HOLD) @(posedge clk);
        stall_sink = 1'b0;
      end else if (no_idle || $urandom_range(0, 3) != 0) begin
        token_ready <= 1'b1;
        @(posedge clk);
      end else begin
        token_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // punctuation, an escaped string, a float with exponent, a keyword
    // closed by a bracket, a lone minus, a stray code point, end inside a string
    send_text("{\"\\q\":[1.5e+3,true]}");
    send_text("-x");
    send_word(21'h10FFFF, 3'd4);
    send_char("\"");
    send_word(21'd0, 3'd1);

    while (words_sent < 180) send_random_token();
    no_idle = 1'b1;
    while (words_sent < 260) send_random_token();

    // keep offering words while the token side is held off
    stall_sink = 1'b1;
    repeat (12) send_random_token();
    no_idle = 1'b0;
    drain_tokens();

    while (words_sent < RANDOM_END) send_random_token();
    drain_tokens();
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("scanned %0d code points with random gaps and back-pressure;", words_sent);
    $display("%0d tokens checked, %0d mismatches", tokens_checked, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/jts_pkg.sv
design/json_token_scanner_core.sv
design/jts_checker.sv
verif/jts_token_checker.sv
verif/tb_json_token_scanner_core.sv
